// ===== design/dtks_pkg.sv =====
// shared types, note increments and the sine table for the dual-tone synth
package dtks_pkg;

  localparam int unsigned TableSize = 256;
  localparam int unsigned TableBits = $clog2(TableSize);
  localparam int unsigned PhaseW    = 32;
  localparam int unsigned SineW     = 11;
  localparam int unsigned SampleW   = 12;
  localparam int unsigned DacW      = 16;
  localparam int unsigned NumKeys   = 7;
  localparam int unsigned KeyIdxW   = $clog2(NumKeys);

  localparam logic [DacW-1:0]    DacCmd   = 16'h3000;
  localparam logic [SampleW-1:0] MidCode  = 12'h800;

  // item kinds
  typedef enum logic {
    KIND_KEYS = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  typedef logic [PhaseW-1:0]       phase_t;
  typedef logic signed [SineW-1:0] sine_t;

  typedef struct packed {
    phase_t step_one;
    phase_t step_two;
  } steps_t;

  // phase increments, floor(f * 2^32 / 25000)
  localparam longint unsigned SampleRate = 25000;
  localparam phase_t StepF = phase_t'((64'd698  << 32) / SampleRate);
  localparam phase_t StepG = phase_t'((64'd784  << 32) / SampleRate);
  localparam phase_t StepA = phase_t'((64'd880  << 32) / SampleRate);
  localparam phase_t StepB = phase_t'((64'd988  << 32) / SampleRate);
  localparam phase_t StepC = phase_t'((64'd1047 << 32) / SampleRate);
  localparam phase_t StepD = phase_t'((64'd1175 << 32) / SampleRate);
  localparam phase_t StepE = phase_t'((64'd1319 << 32) / SampleRate);

  function automatic phase_t note_step(input logic [KeyIdxW-1:0] key);
    phase_t step;
    case (key)
      3'd0:    step = StepF;
      3'd1:    step = StepG;
      3'd2:    step = StepA;
      3'd3:    step = StepB;
      3'd4:    step = StepC;
      3'd5:    step = StepD;
      3'd6:    step = StepE;
      default: step = '0;
    endcase
    return step;
  endfunction

  // sine table, built at elaboration with a q61 angle and taylor series
  localparam int unsigned        QBits     = 61;
  localparam logic [63:0]        PiQ61     = 64'h6487ED5110B4611A;
  localparam logic [63:0]        HalfPiQ61 = 64'h3243F6A8885A308D;
  localparam logic [63:0]        SineDen   = 64'(1000 * TableSize);
  localparam logic [63:0]        SineAmpl  = 64'd1023;
  localparam int unsigned        SeriesLen = 12;

  // (2k)(2k+1) for taylor term k, lowest term in the low slice
  localparam logic [SeriesLen*16-1:0] SeriesDen = {
    16'd600, 16'd506, 16'd420, 16'd342, 16'd272, 16'd210,
    16'd156, 16'd110, 16'd72,  16'd42,  16'd20,  16'd6
  };

  function automatic sine_t sine_entry(input int unsigned idx);
    logic [63:0]  num;
    logic [63:0]  whole;
    logic [63:0]  rem;
    logic [63:0]  frac;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  t;
    logic [63:0]  s;
    logic [63:0]  mag;
    logic [127:0] prod;
    logic         neg;
    num   = 64'(idx) * 64'd6283;
    whole = num / SineDen;
    rem   = num % SineDen;
    frac  = '0;
    neg   = 1'b0;
    for (int b = 0; b < QBits; b++) begin
      rem  = rem << 1;
      frac = frac << 1;
      if (rem >= SineDen) begin
        rem     = rem - SineDen;
        frac[0] = 1'b1;
      end
    end
    x = (whole << QBits) | frac;
    if (x >= PiQ61) begin
      x   = x - PiQ61;
      neg = 1'b1;
    end
    if (x > HalfPiQ61) begin
      x = PiQ61 - x;
    end
    prod = 128'(x) * 128'(x);
    x2   = 64'(prod >> QBits);
    t    = x;
    s    = x;
    for (int k = 1; k <= SeriesLen; k++) begin
      prod  = 128'(t) * 128'(x2);
      t     = 64'(prod >> QBits) / 64'(SeriesDen[(k - 1) * 16 +: 16]);
      if (k % 2 == 1) begin
        s = s - t;
      end else begin
        s = s + t;
      end
    end
    prod = 128'(s) * 128'(SineAmpl);
    mag  = 64'(prod >> QBits);
    if (mag > SineAmpl) begin
      mag = SineAmpl;
    end
    return neg ? -sine_t'(mag) : sine_t'(mag);
  endfunction

  function automatic logic [TableSize*SineW-1:0] build_sine_rom();
    logic [TableSize*SineW-1:0] rom;
    rom = '0;
    for (int unsigned i = 0; i < TableSize; i++) begin
      rom[i*SineW +: SineW] = sine_entry(i);
    end
    return rom;
  endfunction

  localparam logic [TableSize*SineW-1:0] SineRom = build_sine_rom();

  function automatic sine_t sine_lookup(input phase_t phase);
    logic [TableBits-1:0] idx;
    idx = phase[PhaseW-1 -: TableBits];
    return sine_t'(SineRom[32'(idx)*SineW +: SineW]);
  endfunction

endpackage

// ===== design/dtks_tone_sel.sv =====
// key pattern decode and the two phase increment registers
module dtks_tone_sel (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  logic [dtks_pkg::NumKeys-1:0]    key_pattern_i,
  output dtks_pkg::steps_t                steps_o
);
  import dtks_pkg::*;

  logic [KeyIdxW-1:0] low_key;
  logic [KeyIdxW-1:0] high_key;
  logic [KeyIdxW:0]   key_count;
  phase_t             step_one_d, step_one_q;
  phase_t             step_two_d, step_two_q;

  // lowest and highest pressed key plus count
  always_comb begin
    low_key   = '0;
    high_key  = '0;
    key_count = '0;
    for (int k = NumKeys - 1; k >= 0; k--) begin
      if (key_pattern_i[k]) begin
        low_key = KeyIdxW'(k);
      end
    end
    for (int k = 0; k < NumKeys; k++) begin
      if (key_pattern_i[k]) begin
        high_key  = KeyIdxW'(k);
        key_count = key_count + (KeyIdxW+1)'(1);
      end
    end
  end

  always_comb begin
    step_one_d = step_one_q;
    step_two_d = step_two_q;
    if (load_i) begin
      if (key_count == (KeyIdxW+1)'(1)) begin
        step_one_d = note_step(high_key);
        step_two_d = '0;
      end else if (key_count == (KeyIdxW+1)'(2)) begin
        step_one_d = note_step(high_key);
        step_two_d = note_step(low_key);
      end else begin
        step_one_d = '0;
        step_two_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_one_q <= '0;
      step_two_q <= '0;
    end else begin
      step_one_q <= step_one_d;
      step_two_q <= step_two_d;
    end
  end

  assign steps_o = '{step_one: step_one_q, step_two: step_two_q};

endmodule

// ===== design/dtks_osc.sv =====
// two phase accumulators, sine lookups and the dac sample mix
module dtks_osc (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         tick_i,
  input  dtks_pkg::steps_t             steps_i,
  output logic [dtks_pkg::DacW-1:0]    dac_word_o
);
  import dtks_pkg::*;

  phase_t                    phase_one_d, phase_one_q;
  phase_t                    phase_two_d, phase_two_q;
  sine_t                     sine_one;
  sine_t                     sine_two;
  logic signed [SampleW-1:0] sine_sum;
  logic signed [19:0]        scaled;
  logic [SampleW-1:0]        sample;

  assign phase_one_d = phase_one_q + steps_i.step_one;
  assign phase_two_d = phase_two_q + steps_i.step_two;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_one_q <= '0;
      phase_two_q <= '0;
    end else if (tick_i) begin
      phase_one_q <= phase_one_d;
      phase_two_q <= phase_two_d;
    end
  end

  // lookups use the advanced phases
  assign sine_one = sine_lookup(phase_one_d);
  assign sine_two = sine_lookup(phase_two_d);
  assign sine_sum = SampleW'(sine_one) + SampleW'(sine_two);

  // times 255, floor divide by 256, offset to mid code
  assign scaled = (20'(sine_sum) <<< 8) - 20'(sine_sum);
  assign sample = scaled[19:8] + MidCode;

  assign dac_word_o = DacCmd | DacW'(sample);

endmodule

// ===== design/dual_tone_dds_keypad_synth.sv =====
// top level of the dual-tone keypad synthesizer
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------
//  in      | in_valid_i / in_ready_o    | kind_i, key_pattern_i
//  out     | out_valid_o / out_ready_i  | dac_word_o
//
// one beat is taken every cycle while in_ready_o is high; a sample tick sits
// in the item register after its accepting edge and its dac word is loaded
// into the result register when the tick advances, which raises out_valid_o
// key-update beats produce no output beat and never stall
// a tick stalls in the item register only while the result register holds
// an untaken word and out_ready_i is low; in_ready_o then drops
// reset clears the phases, the increments and all valid flags
module dual_tone_dds_keypad_synth (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            kind_i,
  input  logic [dtks_pkg::NumKeys-1:0]    key_pattern_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dtks_pkg::DacW-1:0]       dac_word_o
);
  import dtks_pkg::*;

  // item register
  logic                item_vld_d, item_vld_q;
  kind_e               item_kind_q;
  logic [NumKeys-1:0]  item_keys_q;

  // result register
  logic                out_vld_d, out_vld_q;
  logic [DacW-1:0]     dac_q;

  logic                in_fire;
  logic                advance;
  logic                tick_fire;
  logic                keys_fire;
  steps_t              steps;
  logic [DacW-1:0]     dac_next;

  assign in_fire = in_valid_i & in_ready_o;

  // a tick may move on when the result register is empty or being drained
  assign advance   = item_vld_q
                   & ~((item_kind_q == KIND_TICK) & out_vld_q & ~out_ready_i);
  assign tick_fire = advance & (item_kind_q == KIND_TICK);
  assign keys_fire = advance & (item_kind_q == KIND_KEYS);

  assign in_ready_o = ~item_vld_q | advance;

  always_comb begin
    item_vld_d = item_vld_q;
    if (in_fire) begin
      item_vld_d = 1'b1;
    end else if (advance) begin
      item_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_kind_q <= kind_e'(kind_i);
      item_keys_q <= key_pattern_i;
    end
  end

  // increments load on key-update beats
  dtks_tone_sel u_tone_sel (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (keys_fire),
    .key_pattern_i (item_keys_q),
    .steps_o       (steps)
  );

  // phases advance and the sample is formed on tick beats
  dtks_osc u_osc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (tick_fire),
    .steps_i    (steps),
    .dac_word_o (dac_next)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (tick_fire) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      dac_q <= dac_next;
    end
  end

  assign out_valid_o = out_vld_q;
  assign dac_word_o  = dac_q;

endmodule
